### hw/rtl/rmt_pkg.sv
// package: command and status bundles shared by the range maximum tree modules
`timescale 1ns / 1ps

package rmt_pkg;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clr_step;  // zero one node of the clearing pass
		logic load;      // capture a new item
		logic leaf_wr;   // write the new value into its leaf
		logic sib_rd;    // read the sibling of the current node
		logic up_wr;     // write the parent as max of carry and sibling
		logic q_lo;      // query: left boundary step
		logic q_hi;      // query: right boundary step and level shift
		logic out_load;  // move the query maximum to the result register
	} rmt_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_query;  // offered item is a range query
		logic wr_ok;     // offered write targets an existing leaf
		logic par_root;  // parent of the current node is the root
		logic lo_lt_hi;  // query window still open
		logic clr_last;  // clearing pass is at its last node
	} rmt_sts_t;

endpackage

### hw/rtl/rmt_item_if.sv
// interface: input item channel with valid/ready handshake
`timescale 1ns / 1ps

interface rmt_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [9:0]  position;
	logic [10:0] range_end;
	logic [31:0] new_value;

	modport source (output valid, output mode, output position, output range_end,
		output new_value, input ready);
	modport sink (input valid, input mode, input position, input range_end,
		input new_value, output ready);
endinterface

### hw/rtl/rmt_result_if.sv
// interface: result channel with valid/ready handshake
`timescale 1ns / 1ps

interface rmt_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] range_max;

	modport source (output valid, output range_max, input ready);
	modport sink (input valid, input range_max, output ready);
endinterface

### hw/rtl/rmt_ctrl.sv
// controller: state machine sequencing clear, update and query walks
`timescale 1ns / 1ps

module rmt_ctrl
	import rmt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  rmt_sts_t  sts,
	output rmt_cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_U_LEAF = 3'd2;
	localparam logic [2:0] ST_U_RD   = 3'd3;
	localparam logic [2:0] ST_U_WR   = 3'd4;
	localparam logic [2:0] ST_Q_LO   = 3'd5;
	localparam logic [2:0] ST_Q_HI   = 3'd6;
	localparam logic [2:0] ST_Q_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.is_query) begin
						state_nxt = ST_Q_LO;
					end else if (sts.wr_ok) begin
						state_nxt = ST_U_LEAF;
					end
				end
			end
			ST_U_LEAF: begin
				cmd.leaf_wr = 1'b1;
				state_nxt   = ST_U_RD;
			end
			ST_U_RD: begin
				cmd.sib_rd = 1'b1;
				state_nxt  = ST_U_WR;
			end
			ST_U_WR: begin
				cmd.up_wr = 1'b1;
				state_nxt = sts.par_root ? ST_IDLE : ST_U_RD;
			end
			ST_Q_LO: begin
				if (sts.lo_lt_hi) begin
					cmd.q_lo  = 1'b1;
					state_nxt = ST_Q_HI;
				end else begin
					state_nxt = ST_Q_OUT;
				end
			end
			ST_Q_HI: begin
				cmd.q_hi  = 1'b1;
				state_nxt = ST_Q_LO;
			end
			ST_Q_OUT: begin
				// wait for the result register to be free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### hw/rtl/rmt_dp.sv
// datapath: node memory, walk registers and max compares
`timescale 1ns / 1ps

module rmt_dp
	import rmt_pkg::*;
#(
	parameter int LEAVES     = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mode,
	input  logic [9:0]  position,
	input  logic [10:0] range_end,
	input  logic [31:0] new_value,
	input  rmt_cmd_t    cmd,
	output rmt_sts_t    sts,
	output logic [31:0] range_max
);

	localparam int NODES = 2 * LEAVES;
	localparam int NW    = $clog2(NODES);        // node address bits
	localparam int IW    = $clog2(NODES + 1);    // walk index bits, holds 2*LEAVES
	localparam int WW    = (IW > 11) ? IW : 11;  // width for input compares
	localparam int VB    = VALUE_BITS;

	logic [VB-1:0] mem [0:NODES-1];

	logic [NW-1:0] cur_q;
	logic [VB-1:0] carry_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic [VB-1:0] best_q;
	logic          fold_q;
	logic [VB-1:0] rd_data_q;
	logic [NW-1:0] clr_addr_q;
	logic [31:0]   range_max_q;

	logic [WW-1:0] pos_w;
	logic [WW-1:0] end_w;
	logic [WW-1:0] leaves_w;
	logic [WW-1:0] end_c;
	logic          empty;
	logic [WW-1:0] lo_init;
	logic [WW-1:0] hi_init;
	logic [WW-1:0] leaf_w;
	logic [VB+31:0] val_ext;
	logic [VB+31:0] res_ext;
	logic [IW-1:0] hi_dec;
	logic [NW-1:0] parent;
	logic [VB-1:0] up_max;
	logic [VB-1:0] fold_max;
	logic          rd_en;
	logic [NW-1:0] rd_addr;
	logic          lo_rd;
	logic          hi_rd;
	logic          wr_en;
	logic [NW-1:0] wr_addr;
	logic [VB-1:0] wr_data;

	// item decode
	assign pos_w    = WW'(position);
	assign end_w    = WW'(range_end);
	assign leaves_w = WW'(LEAVES);
	assign end_c    = (end_w > leaves_w) ? leaves_w : end_w;
	assign empty    = (pos_w >= end_c);
	assign lo_init  = empty ? '0 : pos_w + leaves_w;
	assign hi_init  = empty ? '0 : end_c + leaves_w;
	assign leaf_w   = pos_w + leaves_w;
	assign val_ext  = {{VB{1'b0}}, new_value};
	assign res_ext  = {32'd0, best_q};

	assign hi_dec   = hi_q - IW'(1);
	assign parent   = {1'b0, cur_q[NW-1:1]};
	assign up_max   = (carry_q > rd_data_q) ? carry_q : rd_data_q;
	assign fold_max = (best_q > rd_data_q) ? best_q : rd_data_q;

	assign lo_rd = cmd.q_lo & lo_q[0];
	assign hi_rd = cmd.q_hi & hi_q[0];

	// memory ports
	assign rd_en   = cmd.sib_rd | lo_rd | hi_rd;
	assign rd_addr = cmd.sib_rd ? (cur_q ^ NW'(1)) :
		(cmd.q_lo ? lo_q[NW-1:0] : hi_dec[NW-1:0]);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_addr_q;
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.leaf_wr) begin
			wr_en   = 1'b1;
			wr_addr = cur_q;
			wr_data = carry_q;
		end else if (cmd.up_wr) begin
			wr_en   = 1'b1;
			wr_addr = parent;
			wr_data = up_max;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			fold_q     <= 1'b0;
		end else begin
			fold_q <= lo_rd | hi_rd;
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + NW'(1);
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q   <= leaf_w[NW-1:0];
			carry_q <= val_ext[VB-1:0];
			lo_q    <= lo_init[IW-1:0];
			hi_q    <= hi_init[IW-1:0];
			best_q  <= '0;
		end else begin
			if (fold_q) begin
				best_q <= fold_max;
			end
			if (cmd.up_wr) begin
				cur_q   <= parent;
				carry_q <= up_max;
			end
			if (lo_rd) begin
				lo_q <= lo_q + IW'(1);
			end
			if (cmd.q_hi) begin
				lo_q <= lo_q >> 1;
				hi_q <= (hi_q[0] ? hi_dec : hi_q) >> 1;
			end
		end
		if (cmd.out_load) begin
			range_max_q <= res_ext[31:0];
		end
	end

	assign sts.is_query = mode;
	assign sts.wr_ok    = (pos_w < leaves_w);
	assign sts.par_root = (cur_q[NW-1:1] == (NW-1)'(1));
	assign sts.lo_lt_hi = (lo_q < hi_q);
	assign sts.clr_last = (clr_addr_q == NW'(NODES - 1));

	assign range_max = range_max_q;

endmodule

### hw/rtl/range_max_tree_unit.sv
// top level: segment tree of maxima with leaf write and range maximum query
`timescale 1ns / 1ps
//
//  channel  dir  fields                                  transfer means
//  item     in   mode, position, range_end, new_value   one leaf write or one query
//  result   out  range_max                               maximum of one query
//
//  walks: a leaf write keeps item ready low after its transfer for one leaf write and then
//  a sibling read plus a parent write per level
//  a query keeps it low for a left and a right step per level, then to close and load the result
//  reset: a clearing pass zeroes all 2*LEAVES nodes, item ready stays low until it ends
//  stalls: a finished query waits in the result register while the next item is taken;
//  only a second query result stalls behind it
//
module range_max_tree_unit
	import rmt_pkg::*;
#(
	parameter int LEAVES     = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	rmt_item_if.sink            item,
	rmt_result_if.source        result
);

	rmt_cmd_t cmd;
	rmt_sts_t sts;

	// sequencing of the clearing pass and of every walk up or across the tree
	rmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// node memory in heap order with the index and maximum registers
	rmt_dp #(
		.LEAVES     (LEAVES),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (item.mode),
		.position  (item.position),
		.range_end (item.range_end),
		.new_value (item.new_value),
		.cmd       (cmd),
		.sts       (sts),
		.range_max (result.range_max)
	);

endmodule
